/* hw/rtl/dfhe_pkg.sv */
package dfhe_pkg;

  // token kinds
  localparam logic [1:0] KIND_LIT   = 2'd0;
  localparam logic [1:0] KIND_MATCH = 2'd1;
  localparam logic [1:0] KIND_EOS   = 2'd2;

  // longest token: header 3 + length code 8 + 5 extra + distance code 5 + 13 extra
  localparam int TOK_BITS = 34;
  localparam int TOK_NW   = 6;
  // packer: up to 7 pending bits on top of one token
  localparam int ACC_W    = TOK_BITS + 7;
  localparam int ACC_NW   = 6;

  localparam logic [8:0]  MIN_LEN  = 9'd3;
  localparam logic [8:0]  MAX_LEN  = 9'd258;
  localparam logic [15:0] MAX_DIST = 16'd32768;
  localparam logic [8:0]  SYM_EOB  = 9'd256;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  literal_byte;
    logic [8:0]  match_length;
    logic [15:0] match_distance;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
    logic       bad_token;
  } out_item_t;

  // one classified token, bits already in stream order (lsb goes first)
  typedef struct packed {
    logic [TOK_BITS-1:0] bits;
    logic [TOK_NW-1:0]   nbits;
    logic                eos;
    logic                bad;
  } tok_t;

  typedef struct packed {
    logic [8:0] bits;
    logic [3:0] n;
  } code_t;

  // fixed literal/length code, bit-reversed so it can be sent lsb first
  function automatic code_t ll_code(input logic [8:0] sym);
    code_t      r;
    logic [8:0] code;
    logic [8:0] aligned;
    if (sym <= 9'd143) begin
      code = 9'h030 + sym;
      r.n  = 4'd8;
    end else if (sym <= 9'd255) begin
      code = 9'h190 + (sym - 9'd144);
      r.n  = 4'd9;
    end else if (sym <= 9'd279) begin
      code = sym - 9'd256;
      r.n  = 4'd7;
    end else begin
      code = 9'h0C0 + (sym - 9'd280);
      r.n  = 4'd8;
    end
    aligned = code << (4'd9 - r.n);
    for (int i = 0; i < 9; i++) begin
      r.bits[i] = aligned[8-i];
    end
    r.bits = r.bits & ((9'd1 << r.n) - 9'd1);
    return r;
  endfunction

endpackage

/* hw/rtl/deflate_fixed_huffman_token_encoder_top.sv */
// fixed-huffman deflate token encoder
// input channel (in_valid/in_ready/in_data): one token per beat, a literal,
//   a length/distance match or end of stream; the first good token of a
//   stream is preceded by the 3-bit block header (final block, fixed codes)
// output channel (out_valid/out_ready/out_data): one packed byte per beat,
//   bits filled lsb first; last_of_run marks a token's final byte,
//   stream_done the last byte of the stream, bad_token a rejected token
// a token is encoded in the cycle it is accepted and written into a small
//   queue; the packer then loads it from the queue register into its own
//   registers, taking the next token as the current one's last byte leaves
// throughput: one byte per cycle from the packer while out_ready is high
// in_ready drops only while the queue is full, so tokens keep flowing
//   while earlier bytes wait on a stalled receiver
// reset (rst_n low, synchronous) empties the queue, drops pending bits and
//   re-arms the header; an end-of-stream token re-arms it and flushes its bits
module deflate_fixed_huffman_token_encoder_top import dfhe_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  tok_t front_tok, q_tok;
  logic q_full, q_valid, q_pop, push;

  // a beat enters whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // classify the token and build its bit string
  dfhe_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (in_data),
    .push  (push),
    .tok   (front_tok)
  );

  // decouples encoding from byte output
  dfhe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_tok),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_tok)
  );

  // bit packer, one byte per beat
  dfhe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_tok),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a rejection is a single zero beat that ends its token and no stream
  a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_token |->
      out_data.last_of_run && !out_data.stream_done && (out_data.out_byte == 8'd0))
    else $error("bad token beat malformed");

  // the stream's last byte also closes its token
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_done |-> out_data.last_of_run)
    else $error("stream_done without last_of_run");

  // nothing comes out the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // queue can only fill when the packer is stalled or busy
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("input stalled with empty queue");

endmodule

/* hw/rtl/dfhe_front.sv */
module dfhe_front import dfhe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t item,
  input  logic     push,
  output tok_t     tok
);

  logic        header_sent_r, header_sent_nxt;
  logic        good;
  logic [7:0]  l;
  logic [14:0] e;
  logic [3:0]  lmsb, dmsb;
  logic [2:0]  leb;
  logic [3:0]  deb;
  logic [8:0]  lsym;
  logic [4:0]  dsym, drev;
  logic [4:0]  lext;
  logic [12:0] dext;
  code_t       llc;
  logic [TOK_BITS-1:0] bits;
  logic [TOK_NW-1:0]   pos;

  always_comb begin
    good = (item.kind == KIND_LIT) || (item.kind == KIND_EOS) ||
           ((item.kind == KIND_MATCH) &&
            (item.match_length >= MIN_LEN) && (item.match_length <= MAX_LEN) &&
            (item.match_distance != 16'd0) && (item.match_distance <= MAX_DIST));

    // length symbol and extra bits
    l    = 8'(item.match_length - MIN_LEN);
    lmsb = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (l[i]) lmsb = 4'(i);
    end
    if (item.match_length == MAX_LEN) begin
      lsym = 9'd285;
      leb  = 3'd0;
    end else if (l < 8'd8) begin
      lsym = 9'd257 + {1'b0, l};
      leb  = 3'd0;
    end else begin
      leb  = 3'(lmsb - 4'd2);
      lsym = 9'd257 + {4'd0, leb, 2'b00} + {1'b0, l >> leb};
    end
    lext = 5'(l & ((8'd1 << leb) - 8'd1));

    // distance symbol and extra bits
    e    = 15'(item.match_distance - 16'd1);
    dmsb = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (e[i]) dmsb = 4'(i);
    end
    if (e < 15'd4) begin
      deb  = 4'd0;
      dsym = 5'(e);
    end else begin
      deb  = dmsb - 4'd1;
      dsym = 5'({deb, 1'b0}) + 5'(e >> deb);
    end
    dext = 13'(e & ((15'd1 << deb) - 15'd1));
    for (int i = 0; i < 5; i++) begin
      drev[i] = dsym[4-i];
    end

    case (item.kind)
      KIND_LIT:   llc = ll_code({1'b0, item.literal_byte});
      KIND_MATCH: llc = ll_code(lsym);
      default:    llc = ll_code(SYM_EOB);
    endcase

    // assemble in stream order
    bits = '0;
    pos  = '0;
    if (!header_sent_r) begin
      bits[2:0] = 3'b011;       // bfinal=1, btype=01
      pos       = TOK_NW'(3);
    end
    bits = bits | (TOK_BITS'(llc.bits) << pos);
    pos  = pos + TOK_NW'(llc.n);
    if (item.kind == KIND_MATCH) begin
      bits = bits | (TOK_BITS'(lext) << pos);
      pos  = pos + TOK_NW'(leb);
      bits = bits | (TOK_BITS'(drev) << pos);
      pos  = pos + TOK_NW'(5);
      bits = bits | (TOK_BITS'(dext) << pos);
      pos  = pos + TOK_NW'(deb);
    end

    tok.bits  = bits;
    tok.nbits = pos;
    tok.eos   = (item.kind == KIND_EOS);
    tok.bad   = !good;

    header_sent_nxt = header_sent_r;
    if (push && good) begin
      header_sent_nxt = (item.kind != KIND_EOS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_sent_r <= 1'b0;
    end else begin
      header_sent_r <= header_sent_nxt;
    end
  end

endmodule

/* hw/rtl/dfhe_queue.sv */
module dfhe_queue import dfhe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output tok_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t          mem [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (!push && pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/dfhe_back.sv */
module dfhe_back import dfhe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  tok_t      q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic              busy_r, busy_nxt;
  logic              eos_r, eos_nxt;
  logic              bad_r, bad_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt, base_acc;
  logic [ACC_NW-1:0] cnt_r, cnt_nxt, base_cnt;
  logic              last, fire, finish, take;

  always_comb begin
    out_valid = busy_r && (bad_r || (cnt_r >= ACC_NW'(8)) || (eos_r && cnt_r != '0));
    last      = bad_r || (eos_r ? (cnt_r <= ACC_NW'(8)) : (cnt_r < ACC_NW'(16)));
    fire      = out_valid && out_ready;
    finish    = busy_r && (!out_valid || (fire && last));
    take      = q_valid && (!busy_r || finish);
    q_pop     = take;

    out_data.out_byte    = bad_r ? 8'd0 : acc_r[7:0];
    out_data.last_of_run = last;
    out_data.stream_done = !bad_r && eos_r && last;
    out_data.bad_token   = bad_r;

    // packer state once this cycle's beat is gone
    if (fire && !bad_r) begin
      base_acc = acc_r >> 8;
      base_cnt = cnt_r - ACC_NW'(8);
    end else begin
      base_acc = acc_r;
      base_cnt = cnt_r;
    end
    if (finish && eos_r && !bad_r) begin
      base_acc = '0;
      base_cnt = '0;
    end

    busy_nxt = busy_r;
    eos_nxt  = eos_r;
    bad_nxt  = bad_r;
    acc_nxt  = base_acc;
    cnt_nxt  = base_cnt;
    if (take) begin
      busy_nxt = 1'b1;
      eos_nxt  = q_data.eos;
      bad_nxt  = q_data.bad;
      if (!q_data.bad) begin
        acc_nxt = base_acc | (ACC_W'(q_data.bits) << base_cnt[2:0]);
        cnt_nxt = base_cnt + ACC_NW'(q_data.nbits);
      end
    end else if (finish) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      eos_r  <= 1'b0;
      bad_r  <= 1'b0;
      acc_r  <= '0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      eos_r  <= eos_nxt;
      bad_r  <= bad_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* tb/sv/dfhe_bitstream_checker.sv */
`timescale 1ns / 100ps

module dfhe_bitstream_checker import dfhe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        expect_depth,
  output int        bytes_seen
);

  // mirror of the encoder's carried state
  logic [6:0] held_bits;
  logic [2:0] held_count;
  logic       header_done;

  // scratch packer for the token being encoded
  logic [7:0] pack_byte;
  int         pack_fill;
  logic [7:0] token_bytes[$];

  out_item_t  expected_bytes[$];

  task automatic put_bit(input logic b);
    pack_byte[pack_fill] = b;
    pack_fill++;
    if (pack_fill == 8) begin
      token_bytes.push_back(pack_byte);
      pack_byte = '0;
      pack_fill = 0;
    end
  endtask

  task automatic put_lsb_first(input int unsigned value, input int n);
    for (int i = 0; i < n; i++) put_bit(value[i]);
  endtask

  task automatic put_msb_first(input int unsigned value, input int n);
    for (int i = n - 1; i >= 0; i--) put_bit(value[i]);
  endtask

  task automatic put_symbol(input int unsigned sym);
    if (sym <= 143) put_msb_first(sym + 'h30, 8);
    else if (sym <= 255) put_msb_first(sym - 144 + 'h190, 9);
    else if (sym <= 279) put_msb_first(sym - 256, 7);
    else put_msb_first(sym - 280 + 'hC0, 8);
  endtask

  task automatic put_match_length(input int unsigned len);
    int unsigned base;
    int unsigned ebits;
    int unsigned sym;
    base = 11;
    ebits = 1;
    sym = 265;
    if (len <= 10) begin
      put_symbol(254 + len);
    end else if (len == MAX_LEN) begin
      put_symbol(285);
    end else begin
      while (len >= base + (4 << ebits)) begin
        base += 4 << ebits;
        ebits++;
        sym += 4;
      end
      put_symbol(sym + ((len - base) >> ebits));
      put_lsb_first(len - base, ebits);
    end
  endtask

  task automatic put_match_distance(input int unsigned distance);
    int unsigned base;
    int unsigned ebits;
    int unsigned code;
    base = 5;
    ebits = 1;
    code = 4;
    if (distance <= 4) begin
      put_msb_first(distance - 1, 5);
    end else begin
      while (distance >= base + (2 << ebits)) begin
        base += 2 << ebits;
        ebits++;
        code += 2;
      end
      put_msb_first(code + ((distance - base) >> ebits), 5);
      put_lsb_first(distance - base, ebits);
    end
  endtask

  // work out the bytes one accepted token completes
  task automatic encode_token(input in_item_t tok);
    logic      bad;
    int        nb;
    out_item_t r;
    case (tok.kind)
      KIND_LIT, KIND_EOS: bad = 1'b0;
      KIND_MATCH: bad = tok.match_length < MIN_LEN || tok.match_length > MAX_LEN ||
                        tok.match_distance == '0 || tok.match_distance > MAX_DIST;
      default: bad = 1'b1;
    endcase
    if (bad) begin
      r = '{out_byte: 8'h00, last_of_run: 1'b1, stream_done: 1'b0, bad_token: 1'b1};
      expected_bytes.push_back(r);
      return;
    end
    token_bytes.delete();
    pack_byte = {1'b0, held_bits};
    pack_fill = held_count;
    if (!header_done) begin
      put_lsb_first(1, 1);
      put_lsb_first(1, 2);
      header_done = 1'b1;
    end
    case (tok.kind)
      KIND_LIT: put_symbol(tok.literal_byte);
      KIND_MATCH: begin
        put_match_length(tok.match_length);
        put_match_distance(tok.match_distance);
      end
      default: begin
        put_symbol(SYM_EOB);
        if (pack_fill > 0) put_lsb_first(0, 8 - pack_fill);
      end
    endcase
    if (tok.kind == KIND_EOS) begin
      held_bits = '0;
      held_count = '0;
      header_done = 1'b0;
    end else begin
      held_bits = pack_byte[6:0];
      held_count = pack_fill[2:0];
    end
    nb = (token_bytes.size() > 5) ? 5 : token_bytes.size();
    for (int i = 0; i < nb; i++) begin
      r.out_byte = token_bytes[i];
      r.last_of_run = (i == nb - 1);
      r.stream_done = (i == nb - 1) && (tok.kind == KIND_EOS);
      r.bad_token = 1'b0;
      expected_bytes.push_back(r);
    end
  endtask

  task automatic compare_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      held_bits = '0;
      held_count = '0;
      header_done = 1'b0;
      expected_bytes.delete();
      fail_count = 0;
      bytes_seen = 0;
    end else begin
      if (in_valid && in_ready) encode_token(in_data);
      if (out_valid && out_ready) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected beat, expected none, got %h", $time, out_data);
        end else begin
          want = expected_bytes.pop_front();
          compare_field("out_byte", want.out_byte, out_data.out_byte);
          compare_field("last_of_run", want.last_of_run, out_data.last_of_run);
          compare_field("stream_done", want.stream_done, out_data.stream_done);
          compare_field("bad_token", want.bad_token, out_data.bad_token);
        end
      end
    end
    expect_depth <= expected_bytes.size();
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import dfhe_pkg::*;

  // the one kind code the encoder has no meaning for
  localparam logic [1:0] KIND_RSVD = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int expect_depth;
  int bytes_seen;

  // idling knobs, in percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // receiver hold-off: length set once by the stimulus, counted by the receiver
  int hold_len = 0;
  int hold_count = 0;

  int tokens_sent = 0;
  int streams_closed = 0;

  deflate_fixed_huffman_token_encoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // watches both channels, predicts the bitstream and compares every beat
  dfhe_bitstream_checker bitstream_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .expect_depth (expect_depth),
    .bytes_seen   (bytes_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or a solid hold-off while one is requested
  always @(posedge clk) begin
    if (hold_count < hold_len) begin
      out_ready <= 1'b0;
      hold_count++;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // every field random, so unused fields carry noise
  function automatic in_item_t noise_token(input logic [1:0] k);
    in_item_t t;
    t.kind = k;
    t.literal_byte = 8'($urandom);
    t.match_length = 9'($urandom);
    t.match_distance = 16'($urandom);
    return t;
  endfunction

  function automatic in_item_t literal_token(input logic [7:0] b);
    in_item_t t;
    t = noise_token(KIND_LIT);
    t.literal_byte = b;
    return t;
  endfunction

  function automatic in_item_t match_token(input logic [8:0] len,
                                           input logic [15:0] distance);
    in_item_t t;
    t = noise_token(KIND_MATCH);
    t.match_length = len;
    t.match_distance = distance;
    return t;
  endfunction

  // legal length, weighted toward the code-table edges
  function automatic logic [8:0] pick_length();
    case ($urandom_range(0, 3))
      0: return 9'($urandom_range(3, 10));
      1: return 9'($urandom_range(11, 257));
      2: return 9'($urandom_range(250, 258));
      default: return 9'($urandom_range(3, 258));
    endcase
  endfunction

  // legal distance, spread evenly over the octaves so every extra-bit count shows up
  function automatic logic [15:0] pick_distance();
    int unsigned e;
    int unsigned lo;
    int unsigned hi;
    e = $urandom_range(0, 15);
    lo = 1 << e;
    hi = (2 << e) - 1;
    if (hi > 32768) hi = 32768;
    return 16'($urandom_range(lo, hi));
  endfunction

  // one token inside a stream: mostly good, some rejects
  function automatic in_item_t stream_token();
    int unsigned roll;
    in_item_t    t;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      t = literal_token(8'($urandom));
    end else if (roll < 92) begin
      t = match_token(pick_length(), pick_distance());
    end else if (roll < 98) begin
      // a match with one field pushed out of range
      t = match_token(pick_length(), pick_distance());
      case ($urandom_range(0, 2))
        0: t.match_length = 9'($urandom_range(0, 2));
        1: t.match_length = 9'($urandom_range(259, 511));
        default: t.match_distance = $urandom_range(0, 1) ? 16'd0
                                                         : 16'($urandom_range(32769, 65535));
      endcase
    end else begin
      t = noise_token(KIND_RSVD);
    end
    return t;
  endfunction

  // offer one beat, with a random gap first; valid stays up across back-to-back beats
  task automatic send_token(input in_item_t tok);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= tok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tokens_sent++;
    if (tok.kind == KIND_EOS) streams_closed++;
  endtask

  // sender goes quiet until every predicted byte has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expect_depth != 0) @(posedge clk);
  endtask

  // whole streams with random content until the phase has its share of tokens
  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
    int start;
    int n;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = tokens_sent;
    while (tokens_sent - start < n_items) begin
      n = $urandom_range(1, 24);
      repeat (n) send_token(stream_token());
      send_token(noise_token(KIND_EOS));
    end
    drain();
  endtask

  initial begin
    in_item_t t;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty stream first, with the header still pending
    send_token(noise_token(KIND_EOS));
    // reject while the header is pending: header must stay pending
    send_token(match_token(9'd2, 16'd1));
    // literal code-table edges
    send_token(literal_token(8'd0));
    send_token(literal_token(8'd143));
    send_token(literal_token(8'd144));
    t = '{kind: KIND_LIT, literal_byte: 8'd255, match_length: '1, match_distance: '1};
    send_token(t);
    // length and distance edges, up to the longest match code
    send_token(match_token(9'd3, 16'd1));
    send_token(match_token(9'd10, 16'd4));
    send_token(match_token(9'd11, 16'd5));
    send_token(match_token(9'd131, 16'd257));
    send_token(match_token(9'd227, 16'd16384));
    send_token(match_token(9'd257, 16'd32768));
    send_token(match_token(9'd258, 16'd24577));
    // out-of-range matches and the unknown kind
    send_token(match_token(9'd259, 16'd1));
    send_token(match_token(9'd3, 16'd0));
    send_token(match_token(9'd3, 16'd32769));
    send_token(match_token(9'd511, 16'd65535));
    send_token(noise_token(KIND_RSVD));
    send_token(literal_token(8'd65));
    send_token(noise_token(KIND_EOS));
    // two ends in a row: second one is another empty stream
    send_token(noise_token(KIND_EOS));
    drain();

    // long receiver hold-off while long matches keep coming, so the queue fills
    hold_len = 300;
    repeat (40) send_token(match_token(9'd257, 16'($urandom_range(24577, 32768))));
    send_token(noise_token(KIND_EOS));
    drain();

    // random streams under each idling mix
    run_phase(0, 0, 90);
    run_phase(84, 0, 90);
    run_phase(0, 84, 90);
    run_phase(24, 24, 90);

    // let any stray late beat show up
    repeat (20) @(posedge clk);

    $display("covered %0d tokens over %0d closed streams, %0d output beats checked",
             tokens_sent, streams_closed, bytes_seen);
    $display("idle mixes: none, sender 84%%, receiver 84%%, both 24%%, plus a long hold-off");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/dfhe_pkg.sv
hw/rtl/dfhe_front.sv
hw/rtl/dfhe_queue.sv
hw/rtl/dfhe_back.sv
hw/rtl/deflate_fixed_huffman_token_encoder_top.sv
tb/sv/dfhe_bitstream_checker.sv
tb/sv/tb_top.sv
